### sv/gsq_pkg.sv
// gsq_pkg: types, constants and helper functions for the goldschmidt square root block
// used by gsq_mac and goldschmidt_sqrt; no dependencies
package gsq_pkg;

	localparam int FRAC_BITS      = 30;
	localparam int MAX_ITERATIONS = 15;

	localparam int LIMB_W  = 32;
	localparam int PROD_W  = 2 * LIMB_W;
	localparam int ACC_W   = 4 * LIMB_W;
	localparam int RAD_W   = FRAC_BITS + 2;
	localparam int GUESS_W = FRAC_BITS + 1;
	localparam int ROOT_W  = FRAC_BITS + 1;
	localparam int REM_W   = 64;
	localparam int YR_W    = RAD_W + 1;
	// y stays below 2^(FRAC_BITS+4): radicand below 4, first guess below 2
	localparam int Y_W     = FRAC_BITS + 4;
	localparam int N_W     = 2 * LIMB_W;
	localparam int SH_W    = 2;
	localparam int OPS_W   = 3;

	localparam int CNT_W      = 4;
	localparam int PREC_W     = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [CNT_W-1:0]  ITER_COUNT_RST = CNT_W'(3);
	localparam logic [PREC_W-1:0] ITER_PREC_RST  = PREC_W'(30);
	localparam logic [PREC_W-1:0] OUT_PREC_RST   = PREC_W'(30);

	localparam logic [CFG_IDX_W-1:0] CFG_ITER_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ITER_PREC  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_PREC   = CFG_IDX_W'(2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_RR,
		ST_Y,
		ST_N,
		ST_ROOT,
		ST_SQ
	} state_t;

	typedef struct packed {
		logic [RAD_W-1:0]   radicand;
		logic [GUESS_W-1:0] initial_guess;
	} in_t;

	typedef struct packed {
		logic [ROOT_W-1:0]       root;
		logic signed [REM_W-1:0] remainder;
		logic                    overflow;
	} res_t;

	typedef struct packed {
		logic              issue;
		logic              first;
		logic [LIMB_W-1:0] a;
		logic [LIMB_W-1:0] b;
		logic [SH_W-1:0]   sh;
	} mac_cmd_t;

	// low bits dropped by a precision setting
	function automatic logic [PREC_W-1:0] prec_shift(input logic [PREC_W-1:0] p);
		logic [PREC_W-1:0] c;
		if (p == '0)
			c = PREC_W'(1);
		else if (p > PREC_W'(FRAC_BITS))
			c = PREC_W'(FRAC_BITS);
		else
			c = p;
		return PREC_W'(FRAC_BITS) - c;
	endfunction

	function automatic logic [N_W-1:0] keep_mask(input logic [PREC_W-1:0] s);
		return {N_W{1'b1}} << s;
	endfunction

endpackage

### sv/gsq_mac.sv
// gsq_mac: shared 32x32 multiplier with registered product and a limb-shifted accumulator
// depends on gsq_pkg
module gsq_mac (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gsq_pkg::mac_cmd_t           cmd,
	output logic [gsq_pkg::ACC_W-1:0]   acc
);

	logic                          v_s1;
	logic                          first_s1;
	logic [gsq_pkg::PROD_W-1:0]    prod_s1;
	logic [gsq_pkg::SH_W-1:0]      sh_s1;
	logic [gsq_pkg::ACC_W-1:0]     acc_q;
	logic [gsq_pkg::ACC_W-1:0]     addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			prod_s1  <= gsq_pkg::PROD_W'(cmd.a) * gsq_pkg::PROD_W'(cmd.b);
			sh_s1    <= cmd.sh;
			first_s1 <= cmd.first;
		end
		if (v_s1) begin
			acc_q <= (first_s1 ? '0 : acc_q) + addend;
		end
	end

	assign addend = gsq_pkg::ACC_W'(prod_s1) << {sh_s1, 5'd0};
	assign acc    = acc_q;

endmodule

### sv/goldschmidt_sqrt.sv
// goldschmidt_sqrt: fixed-point goldschmidt square root with rounding, remainder and overflow
// steps: round, N iterations (rr, y, n), root, square; N is the clamped iteration count
// start is taken only while idle; one shared multiplier does 7 products/iteration
// reset: asynchronous, clears the sequencer and sets the registers to 3, 30 and 30
// results cannot be stalled: done marks each result word for exactly one cycle
// depends on gsq_pkg and gsq_mac
module goldschmidt_sqrt #(
	parameter int MAX_ITERATIONS = gsq_pkg::MAX_ITERATIONS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  gsq_pkg::in_t                     din,
	output logic                             done,
	output gsq_pkg::res_t                    dout,
	input  logic                             cfg_we,
	input  logic [gsq_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [gsq_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int ITW = $clog2(MAX_ITERATIONS + 1);
	localparam int F   = gsq_pkg::FRAC_BITS;
	localparam int LW  = gsq_pkg::LIMB_W;
	localparam int YW  = gsq_pkg::Y_W;
	localparam int NW  = gsq_pkg::N_W;
	localparam int OW  = gsq_pkg::OPS_W;
	localparam int PW  = gsq_pkg::PREC_W;
	localparam int YRW = gsq_pkg::YR_W;
	localparam int RW  = gsq_pkg::ROOT_W;
	localparam logic [YW-1:0] THREE    = YW'(3) << F;
	localparam logic [RW-1:0] ROOT_MAX = {RW{1'b1}};

	gsq_pkg::state_t state_q, state_d;
	logic [OW-1:0]   k_q, k_d;
	logic [OW-1:0]   nops;
	logic            grp_done;
	logic [ITW-1:0]  iter_q;
	logic [ITW-1:0]  cnt;
	logic            done_q;

	logic [gsq_pkg::CNT_W-1:0] iter_cnt_q;
	logic [PW-1:0]             iter_prec_q;
	logic [PW-1:0]             out_prec_q;
	logic [PW-1:0]             si;
	logic [PW-1:0]             so;

	gsq_pkg::in_t       in_q;
	gsq_pkg::res_t      dout_q;
	logic [YRW-1:0]     yr_q;
	logic [YW-1:0]      y_q;
	logic [NW-1:0]      n_q;
	logic [LW-1:0]      r_q;
	logic [2*LW-1:0]    rr_q;
	logic [RW-1:0]      root_q;
	logic               ovf_q;

	gsq_pkg::mac_cmd_t          cmd;
	logic [gsq_pkg::ACC_W-1:0]  acc;

	logic [YRW-1:0]  rq;
	logic [YRW-1:0]  rlow;
	logic [YRW-1:0]  rhalf;
	logic            rup;
	logic [YRW-1:0]  yr;
	logic [NW-1:0]   y64;
	logic [LW-1:0]   r_next;
	logic [NW-1:0]   nmask;
	logic [NW-1:0]   big;

	gsq_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.acc    (acc)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_cnt_q  <= gsq_pkg::ITER_COUNT_RST;
			iter_prec_q <= gsq_pkg::ITER_PREC_RST;
			out_prec_q  <= gsq_pkg::OUT_PREC_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				gsq_pkg::CFG_ITER_COUNT: iter_cnt_q  <= cfg_data[gsq_pkg::CNT_W-1:0];
				gsq_pkg::CFG_ITER_PREC:  iter_prec_q <= cfg_data;
				gsq_pkg::CFG_OUT_PREC:   out_prec_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign si  = gsq_pkg::prec_shift(iter_prec_q);
	assign so  = gsq_pkg::prec_shift(out_prec_q);
	assign cnt = (int'(iter_cnt_q) > MAX_ITERATIONS) ? ITW'(MAX_ITERATIONS) : ITW'(iter_cnt_q);

	// round to nearest even at the output precision
	always_comb begin
		rq    = YRW'(in_q.radicand) >> so;
		rlow  = YRW'(in_q.radicand) & ~YRW'(gsq_pkg::keep_mask(so));
		rhalf = YRW'(1) << (so - PW'(1));
		rup   = (so != '0) && ((rlow > rhalf) || ((rlow == rhalf) && rq[0]));
		yr    = (rq + YRW'(rup)) << so;
	end

	assign y64    = NW'(y_q);
	assign r_next = (y_q > THREE) ? '0 : (LW'((THREE - y_q) >> 1) & LW'(gsq_pkg::keep_mask(si)));
	assign nmask  = n_q & gsq_pkg::keep_mask(so);
	assign big    = NW'(yr_q) << F;

	always_comb begin
		case (state_q)
			gsq_pkg::ST_RR: nops = OW'(1);
			gsq_pkg::ST_Y:  nops = OW'(4);
			gsq_pkg::ST_N:  nops = OW'(2);
			gsq_pkg::ST_SQ: nops = OW'(1);
			default:        nops = '0;
		endcase
	end

	assign grp_done = (k_q == nops + OW'(1));

	// sequencer
	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		cmd       = '0;
		cmd.first = (k_q == '0);
		case (state_q)
			gsq_pkg::ST_IDLE: begin
				if (start)
					state_d = gsq_pkg::ST_ROUND;
			end
			gsq_pkg::ST_ROUND: begin
				k_d     = '0;
				state_d = (cnt == '0) ? gsq_pkg::ST_ROOT : gsq_pkg::ST_RR;
			end
			gsq_pkg::ST_RR: begin
				cmd.a = r_q;
				cmd.b = r_q;
				if (grp_done)
					state_d = gsq_pkg::ST_Y;
			end
			gsq_pkg::ST_Y: begin
				cmd.a  = k_q[1] ? y64[2*LW-1:LW] : y64[LW-1:0];
				cmd.b  = k_q[0] ? rr_q[2*LW-1:LW] : rr_q[LW-1:0];
				cmd.sh = gsq_pkg::SH_W'(k_q[1]) + gsq_pkg::SH_W'(k_q[0]);
				if (grp_done)
					state_d = gsq_pkg::ST_N;
			end
			gsq_pkg::ST_N: begin
				cmd.a  = k_q[0] ? n_q[2*LW-1:LW] : n_q[LW-1:0];
				cmd.b  = r_q;
				cmd.sh = gsq_pkg::SH_W'(k_q[0]);
				if (grp_done)
					state_d = ((iter_q + ITW'(1)) == cnt) ? gsq_pkg::ST_ROOT : gsq_pkg::ST_RR;
			end
			gsq_pkg::ST_ROOT: begin
				k_d     = '0;
				state_d = gsq_pkg::ST_SQ;
			end
			gsq_pkg::ST_SQ: begin
				cmd.a = LW'(root_q);
				cmd.b = LW'(root_q);
				if (grp_done)
					state_d = gsq_pkg::ST_IDLE;
			end
			default: begin
				state_d = gsq_pkg::ST_IDLE;
			end
		endcase
		if (nops != '0) begin
			cmd.issue = (k_q < nops);
			k_d       = grp_done ? '0 : k_q + OW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gsq_pkg::ST_IDLE;
			k_q     <= '0;
			iter_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			done_q  <= (state_q == gsq_pkg::ST_SQ) && grp_done;
			if (state_q == gsq_pkg::ST_ROUND)
				iter_q <= '0;
			else if ((state_q == gsq_pkg::ST_N) && grp_done)
				iter_q <= iter_q + ITW'(1);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			gsq_pkg::ST_IDLE: begin
				if (start)
					in_q <= din;
			end
			gsq_pkg::ST_ROUND: begin
				yr_q <= yr;
				y_q  <= YW'(yr);
				n_q  <= NW'(yr);
				r_q  <= LW'(in_q.initial_guess);
			end
			gsq_pkg::ST_RR: begin
				if (grp_done)
					rr_q <= acc[2*LW-1:0];
			end
			gsq_pkg::ST_Y: begin
				if (grp_done)
					y_q <= acc[2*F +: YW] & YW'(gsq_pkg::keep_mask(si));
			end
			gsq_pkg::ST_N: begin
				if (grp_done) begin
					n_q <= acc[F +: NW] & gsq_pkg::keep_mask(si);
					r_q <= r_next;
				end
			end
			gsq_pkg::ST_ROOT: begin
				ovf_q  <= (nmask > NW'(ROOT_MAX));
				root_q <= (nmask > NW'(ROOT_MAX)) ? ROOT_MAX : RW'(nmask);
			end
			gsq_pkg::ST_SQ: begin
				if (grp_done) begin
					dout_q.root      <= root_q;
					dout_q.remainder <= $signed(big - acc[2*LW-1:0]);
					dout_q.overflow  <= ovf_q;
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != gsq_pkg::ST_IDLE);
	assign done = done_q;
	assign dout = dout_q;

	a_done_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	a_done_after_sq: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == gsq_pkg::ST_SQ) else $error("result without square step");

	a_accept_round: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == gsq_pkg::ST_ROUND)) else $error("word not taken");

	a_mac_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !cmd.issue) else $error("multiplier issued while idle");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && dout.overflow) |-> (dout.root == ROOT_MAX)) else $error("overflow without saturation");

endmodule
